>>> rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg: shared types and constants of the back-reference decompressor
// Command word between parser and copy engine, status codes, state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package lzd_pkg;

  // History window, a power of two (4096 .. 131072)
  localparam int WINDOW_BYTES     = 131072;
  localparam int HIST_AW          = $clog2(WINDOW_BYTES);
  localparam int BYTES_PER_RESULT = 32;
  localparam int CHUNK            = (BYTES_PER_RESULT > 32) ? 32 : BYTES_PER_RESULT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int SIZE_W = 24;
  localparam int LEN_W  = 11;
  localparam int DIST_W = 18;
  localparam int LEFT_W = 8;
  localparam int OUT_W  = 256;

  localparam logic [7:0] OP_END = 8'hFC;
  localparam logic [7:0] OP_RUN = 8'hE0;

  typedef enum logic [2:0] {
    PH_OPCODE,
    PH_BYTE2,
    PH_BYTE3,
    PH_BYTE4,
    PH_LITERALS,
    PH_TRAILING
  } lzd_phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_REF  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_TRUNC    = 2'd3
  } lzd_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LIT,
    B_CHECK,
    B_READ,
    B_WRITE,
    B_EMIT,
    B_TAIL
  } lzd_back_state_t;

  // One command per input byte that causes any result
  typedef struct packed {
    logic              lit_en;
    logic [7:0]        lit_byte;
    logic              copy_en;
    logic [LEN_W-1:0]  copy_len;
    logic [DIST_W-1:0] copy_dist;
    logic              done;
    logic              trunc;
  } lzd_cmd_t;

  typedef struct packed {
    logic idle;
    logic below_size;
  } lzd_back_stat_t;

endpackage

`default_nettype wire

>>> rtl/lzd_ram.sv
// ----------------------------------------------------------------------------
// lzd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzd_fifo.sv
// ----------------------------------------------------------------------------
// lzd_fifo: command queue between parser and copy engine
// Small register queue; read data shows the head entry.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire lzd_pkg::lzd_cmd_t wdata,
  input  wire logic             pop,
  output lzd_pkg::lzd_cmd_t      rdata,
  output logic                  full,
  output logic                  empty
);
  import lzd_pkg::*;

  lzd_cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr;
  logic [QUEUE_AW-1:0]     rd_ptr;
  logic [QUEUE_AW:0]       count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underrun: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance");

endmodule

`default_nettype wire

>>> rtl/lzd_front.sv
// ----------------------------------------------------------------------------
// lzd_front: opcode parser
// Takes one compressed byte per cycle while in_stall is low, tracks the opcode phase and queues
// literal / copy / end-of-stream requests for the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [7:0]             compressed_byte,
  input  wire logic                   last_byte,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire lzd_pkg::lzd_back_stat_t stat,
  input  wire logic                   fifo_full,
  input  wire logic                   fifo_empty,
  output logic                        push,
  output lzd_pkg::lzd_cmd_t            cmd
);
  import lzd_pkg::*;

  lzd_phase_t         phase, phase_next;
  logic [7:0]         ob0, ob0_next;
  logic [7:0]         ob1, ob1_next;
  logic [7:0]         ob2, ob2_next;
  logic [LEFT_W-1:0]  lits_left, lits_left_next;
  logic [LEN_W-1:0]   pend_len, pend_len_next;
  logic [DIST_W-1:0]  pend_dist, pend_dist_next;
  logic               finished, finished_next;

  logic               is_end, is_run, end_wait, accept, work;
  logic               is_done, is_trunc, trailing_ok;
  logic [7:0]         d_b2, d_b3;
  logic [1:0]         d_plain;
  logic [LEN_W-1:0]   d_len;
  logic [DIST_W-1:0]  d_dist;
  logic               decode_now;

  assign is_end      = (compressed_byte >= OP_END);
  assign is_run      = (compressed_byte >= OP_RUN) && !is_end;
  assign trailing_ok = stat.below_size && (compressed_byte[1:0] != 2'b00);

  // End opcode needs the final output count: wait until the engine drains.
  assign end_wait = in_valid && !finished && (phase == PH_OPCODE) && is_end &&
                    !(stat.idle && fifo_empty);
  assign in_stall = fifo_full || end_wait;
  assign accept   = in_valid && !in_stall;
  assign work     = accept && !finished;

  assign d_b2 = (phase == PH_BYTE2) ? compressed_byte : ob1;
  assign d_b3 = (phase == PH_BYTE3) ? compressed_byte : ob2;

  assign decode_now = ((phase == PH_BYTE2) && !ob0[7]) ||
                      ((phase == PH_BYTE3) && (ob0[7:6] == 2'b10)) ||
                      (phase == PH_BYTE4);

  always_comb begin
    if (!ob0[7]) begin
      d_plain = ob0[1:0];
      d_len   = LEN_W'(ob0[4:2]) + 11'd3;
      d_dist  = DIST_W'({ob0[6:5], d_b2}) + 18'd1;
    end else if (!ob0[6]) begin
      d_plain = d_b2[7:6];
      d_len   = LEN_W'(ob0[5:0]) + 11'd4;
      d_dist  = DIST_W'({d_b2[5:0], d_b3}) + 18'd1;
    end else begin
      d_plain = ob0[1:0];
      d_len   = LEN_W'({ob0[3:2], compressed_byte}) + 11'd5;
      d_dist  = DIST_W'({ob0[4], d_b2, d_b3}) + 18'd1;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (work) begin
      unique case (phase) inside
        PH_OPCODE: begin
          if (is_end) begin
            phase_next = trailing_ok ? PH_TRAILING : PH_OPCODE;
          end else if (is_run) begin
            phase_next = PH_LITERALS;
          end else begin
            phase_next = PH_BYTE2;
          end
        end
        PH_BYTE2, PH_BYTE3, PH_BYTE4: begin
          if (decode_now) begin
            phase_next = (d_plain != 2'b00) ? PH_LITERALS : PH_OPCODE;
          end else begin
            phase_next = (phase == PH_BYTE2) ? PH_BYTE3 : PH_BYTE4;
          end
        end
        PH_LITERALS, PH_TRAILING: begin
          if (lits_left == LEFT_W'(1)) begin
            phase_next = PH_OPCODE;
          end
        end
        default: phase_next = PH_OPCODE;
      endcase
    end
  end

  // Command and datapath
  always_comb begin
    cmd            = '0;
    ob0_next       = ob0;
    ob1_next       = ob1;
    ob2_next       = ob2;
    lits_left_next = lits_left;
    pend_len_next  = pend_len;
    pend_dist_next = pend_dist;
    finished_next  = finished;
    is_done        = 1'b0;
    is_trunc       = 1'b0;
    if (work) begin
      unique case (phase) inside
        PH_OPCODE: begin
          if (is_end) begin
            if (trailing_ok) begin
              lits_left_next = LEFT_W'(compressed_byte[1:0]);
            end else begin
              is_done = 1'b1;
            end
          end else if (is_run) begin
            lits_left_next = {1'b0, compressed_byte[4:0], 2'b00} + 8'd4;
            pend_len_next  = '0;
          end else begin
            ob0_next = compressed_byte;
          end
        end
        PH_BYTE2, PH_BYTE3, PH_BYTE4: begin
          if (phase == PH_BYTE2) begin
            ob1_next = compressed_byte;
          end
          if (phase == PH_BYTE3) begin
            ob2_next = compressed_byte;
          end
          if (decode_now) begin
            if (d_plain != 2'b00) begin
              lits_left_next = LEFT_W'(d_plain);
              pend_len_next  = d_len;
              pend_dist_next = d_dist;
            end else begin
              cmd.copy_en   = 1'b1;
              cmd.copy_len  = d_len;
              cmd.copy_dist = d_dist;
            end
          end
        end
        PH_LITERALS, PH_TRAILING: begin
          cmd.lit_en     = 1'b1;
          cmd.lit_byte   = compressed_byte;
          lits_left_next = lits_left - 1'b1;
          if (lits_left == LEFT_W'(1)) begin
            if (phase == PH_TRAILING) begin
              is_done = 1'b1;
            end else begin
              cmd.copy_en   = (pend_len != '0);
              cmd.copy_len  = pend_len;
              cmd.copy_dist = pend_dist;
              pend_len_next = '0;
            end
          end
        end
        default: ;
      endcase
      if (!is_done && last_byte) begin
        if (phase_next == PH_OPCODE) begin
          is_done = 1'b1;
        end else begin
          is_trunc = 1'b1;
        end
      end
      cmd.done      = is_done;
      cmd.trunc     = is_trunc;
      finished_next = is_done || is_trunc;
    end
  end

  assign push = work && (cmd.lit_en || cmd.copy_en || is_done || is_trunc);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_OPCODE;
      finished  <= 1'b0;
      lits_left <= '0;
      pend_len  <= '0;
    end else begin
      phase     <= phase_next;
      finished  <= finished_next;
      lits_left <= lits_left_next;
      pend_len  <= pend_len_next;
    end
  end

  always_ff @(posedge clk) begin
    ob0       <= ob0_next;
    ob1       <= ob1_next;
    ob2       <= ob2_next;
    pend_dist <= pend_dist_next;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
      !(push && fifo_full))
    else $error("parser pushed into a full queue");
  a_quiet_after_finish: assert property (@(posedge clk) disable iff (rst)
      finished |-> !push)
    else $error("request after stream finished");
  a_lits_in_run: assert property (@(posedge clk) disable iff (rst)
      (phase == PH_LITERALS || phase == PH_TRAILING) |-> (lits_left != '0))
    else $error("literal phase with no literals left");

endmodule

`default_nettype wire

>>> rtl/lzd_back.sv
// ----------------------------------------------------------------------------
// lzd_back: copy engine
// Executes queued requests: literals, back-reference copies through the
// history RAM, and end-of-stream markers. Packs bytes into output results.
// ----------------------------------------------------------------------------
`default_nettype none

module lzd_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lzd_pkg::lzd_cmd_t          cmd,
  input  wire logic                      cmd_valid,
  output logic                           cmd_pop,
  input  wire logic [lzd_pkg::SIZE_W-1:0] expected_size,
  output lzd_pkg::lzd_back_stat_t         stat,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [lzd_pkg::OUT_W-1:0]       out_data,
  output logic [5:0]                     out_count,
  output logic                           out_last,
  output logic                           out_done,
  output lzd_pkg::lzd_status_t            out_status
);
  import lzd_pkg::*;

  lzd_back_state_t    state, state_next;
  lzd_cmd_t           cur;
  logic [SIZE_W-1:0]  produced;
  logic [LEN_W-1:0]   left;
  logic [5:0]         fill;
  logic [OUT_W-1:0]   buffer;
  logic               copy_final;
  lzd_status_t        copy_stat;

  logic               out_free, below, bad_ref, write_fin, tail_emit;
  logic [SIZE_W-1:0]  prod_inc, dist_ext;
  logic [LEN_W-1:0]   left_dec;
  logic [5:0]         fill_inc;

  logic               emit, e_final, e_tail;
  logic [OUT_W-1:0]   e_data;
  logic [5:0]         e_count;
  lzd_status_t        e_status;

  logic               ram_we, ram_re;
  logic [7:0]         ram_wdata, ram_rdata;
  logic [HIST_AW-1:0] ram_raddr;

  assign out_free  = !out_valid || !out_stall;
  assign below     = (produced < expected_size);
  assign dist_ext  = SIZE_W'(cur.copy_dist);
  assign bad_ref   = (dist_ext > produced) || (cur.copy_dist > DIST_W'(WINDOW_BYTES));
  assign prod_inc  = produced + 1'b1;
  assign left_dec  = left - 1'b1;
  assign fill_inc  = fill + 1'b1;
  // Copy ends when all bytes are out or the next byte would pass the size
  assign write_fin = (left_dec == '0) || (prod_inc >= expected_size);
  assign tail_emit = cur.trunc || (cur.done && !cur.lit_en && !cur.copy_en);
  assign ram_raddr = HIST_AW'(produced - dist_ext);

  assign stat.idle       = (state == B_IDLE);
  assign stat.below_size = below;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.lit_en) begin
            state_next = B_LIT;
          end else if (cmd.copy_en) begin
            state_next = B_CHECK;
          end else begin
            state_next = B_TAIL;
          end
        end
      end
      B_LIT: begin
        if (out_free) begin
          state_next = cur.copy_en ? B_CHECK : B_TAIL;
        end
      end
      B_CHECK: begin
        if (bad_ref || !below) begin
          if (out_free) begin
            state_next = B_TAIL;
          end
        end else begin
          state_next = B_READ;
        end
      end
      B_READ:  state_next = B_WRITE;
      B_WRITE: begin
        state_next = ((fill_inc == 6'(CHUNK)) || write_fin) ? B_EMIT : B_READ;
      end
      B_EMIT: begin
        if (out_free) begin
          state_next = copy_final ? B_TAIL : B_READ;
        end
      end
      B_TAIL: begin
        if (!tail_emit || out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    cmd_pop   = 1'b0;
    emit      = 1'b0;
    e_final   = 1'b0;
    e_tail    = 1'b0;
    e_data    = '0;
    e_count   = '0;
    e_status  = ST_OK;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = cur.lit_byte;
    unique case (state)
      B_IDLE: cmd_pop = cmd_valid;
      B_LIT: begin
        emit    = 1'b1;
        e_final = !cur.copy_en;
        if (below) begin
          e_data  = OUT_W'(cur.lit_byte);
          e_count = 6'd1;
          ram_we  = out_free;
        end else begin
          e_status = ST_OVERFLOW;
        end
      end
      B_CHECK: begin
        if (bad_ref) begin
          emit     = 1'b1;
          e_final  = 1'b1;
          e_status = ST_BAD_REF;
        end else if (!below) begin
          emit     = 1'b1;
          e_final  = 1'b1;
          e_status = ST_OVERFLOW;
        end
      end
      B_READ: ram_re = 1'b1;
      B_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      B_EMIT: begin
        emit     = 1'b1;
        e_final  = copy_final;
        e_data   = buffer;
        e_count  = fill;
        e_status = copy_stat;
      end
      B_TAIL: begin
        emit     = tail_emit;
        e_tail   = 1'b1;
        e_status = cur.trunc ? ST_TRUNC : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      produced  <= '0;
      fill      <= '0;
    end else begin
      state     <= state_next;
      out_valid <= (emit && out_free) || (out_valid && out_stall);
      if (ram_we) begin
        produced <= prod_inc;
      end
      if (state == B_CHECK) begin
        fill <= '0;
      end else if (state == B_WRITE) begin
        fill <= fill_inc;
      end else if (state == B_EMIT && out_free) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && cmd_valid) begin
      cur <= cmd;
    end
    if (emit && out_free) begin
      out_data   <= e_data;
      out_count  <= e_count;
      out_status <= e_status;
      out_last   <= e_tail || (e_final && !cur.trunc);
      out_done   <= e_tail || (e_final && cur.done && !cur.trunc);
    end
    if (state == B_CHECK) begin
      left   <= cur.copy_len;
      buffer <= '0;
    end else if (state == B_WRITE) begin
      buffer[{fill[4:0], 3'b000} +: 8] <= ram_rdata;
      left       <= left_dec;
      copy_final <= write_fin;
      // bytes still owed at the final write were cut off by the size limit
      copy_stat  <= (write_fin && (left_dec != '0)) ? ST_OVERFLOW : ST_OK;
    end else if (state == B_EMIT && out_free) begin
      buffer <= '0;
    end
  end

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (produced[HIST_AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill <= 6'(CHUNK))
    else $error("result buffer overfilled");
  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
      (state == B_READ) |=> (state == B_WRITE))
    else $error("history read not followed by write");
  a_produced_step: assert property (@(posedge clk) disable iff (rst)
      (produced == $past(produced)) || (produced == $past(produced) + 1'b1))
    else $error("output count jumped");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      out_valid |-> (out_count <= 6'(CHUNK)))
    else $error("result byte count too large");

endmodule

`default_nettype wire

>>> rtl/lz77_back_reference_decompressor_core.sv
// ----------------------------------------------------------------------------
// lz77_back_reference_decompressor_core: RefPack-style stream decompressor
// Parser front end, request queue and copy engine with a history RAM.
// ----------------------------------------------------------------------------
// Opcode and literal bytes are taken one per cycle while in_stall is low. A
// literal result is registered in state B_LIT, after B_IDLE pops its request
// from the queue head. A back reference is taken, its distance is checked,
// and each copied byte is then a read of the history RAM followed by a write,
// since overlapping references read bytes written just before; bytes are
// packed up to 32 per result and a closing step ends the request. While a
// copy runs, input keeps flowing until the 4-entry request queue is full. An
// end opcode is held until the engine has drained, because its trailing
// literals depend on the final output count. The history RAM needs no
// clearing after reset. The user must write expected_size through the cfg
// channel while idle; the block itself does not enforce it.
`default_nettype none

module lz77_back_reference_decompressor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  compressed_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      bytes_0,
  output logic [63:0]      bytes_1,
  output logic [63:0]      bytes_2,
  output logic [63:0]      bytes_3,
  output logic [5:0]       byte_count,
  output logic             last_of_run,
  output logic             stream_done,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] cfg_data
);
  import lzd_pkg::*;

  logic [SIZE_W-1:0] expected_size;
  lzd_cmd_t          push_cmd, head_cmd;
  logic              push, pop, fifo_full, fifo_empty;
  lzd_back_stat_t    back_stat;
  logic [OUT_W-1:0]  out_data;
  lzd_status_t       out_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= '0;
    end else if (cfg_valid && cfg_ready) begin
      expected_size <= cfg_data;
    end
  end

  lzd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .compressed_byte (compressed_byte),
    .last_byte       (last_byte),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .stat            (back_stat),
    .fifo_full       (fifo_full),
    .fifo_empty      (fifo_empty),
    .push            (push),
    .cmd             (push_cmd)
  );

  lzd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_cmd),
    .pop   (pop),
    .rdata (head_cmd),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  lzd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (head_cmd),
    .cmd_valid     (!fifo_empty),
    .cmd_pop       (pop),
    .expected_size (expected_size),
    .stat          (back_stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .out_count     (byte_count),
    .out_last      (last_of_run),
    .out_done      (stream_done),
    .out_status    (out_status)
  );

  assign bytes_0 = out_data[63:0];
  assign bytes_1 = out_data[127:64];
  assign bytes_2 = out_data[191:128];
  assign bytes_3 = out_data[255:192];
  assign status  = out_status;

endmodule

`default_nettype wire
